@@ rtl/tfoc_pkg.sv @@
`default_nettype none
package tfoc_pkg;

    localparam int unsigned CAPACITY_DEF = 64;

    localparam logic [1:0] OP_INGEST = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_COMPLETE  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_BOUNDARY  = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    localparam logic [1:0] REG_SLOTS = 2'd0;
    localparam logic [1:0] REG_RESP  = 2'd1;
    localparam logic [1:0] REG_MIN   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FRAME,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_STORE,
        S_READ_RD,
        S_READ_OUT,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input item
        logic       div_start;
        logic       open_frame;
        logic       scan_init;
        logic       scan_rd;   // issue read at scan index
        logic       scan_next;
        logic       rd_issue;  // issue read at read_index
        logic       store;
        logic       clear;
        logic       set_status;
        logic [2:0] status;
        logic       capture_entry;
        logic       out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       cfg_ok;
        logic       item_bad;
        logic       div_done;
        logic       active;
        logic       frame_neg;
        logic       frame_zero;
        logic       scan_end;
        logic       match;
        logic       full;
        logic       complete_after;
        logic       read_ok;
        logic       out_busy;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/tdoa_frame_observation_collector.sv @@
// TDOA frame observation collector.
// Input channel: i_valid/o_stall with op, slot, ids, range, invalid flag and
// read index; one transaction per item. Output channel: o_valid/i_stall with
// status, count, solvable, complete and entry fields; one result per item.
// Config: i_cfg_we/i_cfg_index/i_cfg_data, write only while idle.
// Path from accept to o_valid: clear, unused op or early reject go straight
// to the output; read reads the entry memory; frame boundary or earlier frame
// ends after the 32-step slot/slots_per_frame divide; ingest runs that divide
// and then a duplicate scan that reads and compares each stored entry.
// One item is processed at a time; o_stall stays high until the result is
// handed to the output register, and the next item can be taken in the cycle
// after that.
// Reset clears the frame and the count and sets the three config registers
// to 1; the entry memory is not cleared (only entries below the count are ever used).
// A stalled result holds in the output register; the next item is taken and
// processed, and its result waits until the register drains.
`default_nettype none
module tdoa_frame_observation_collector #(
    parameter int unsigned CAPACITY = tfoc_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic [31:0]        i_slot_id,
    input  wire logic [15:0]        i_initiator_id,
    input  wire logic [15:0]        i_responder_id,
    input  wire logic signed [31:0] i_range_difference,
    input  wire logic               i_value_invalid,
    input  wire logic [7:0]         i_read_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_status,
    output logic [7:0]              o_obs_count,
    output logic                    o_solvable,
    output logic                    o_frame_complete,
    output logic [31:0]             o_entry_slot_id,
    output logic [15:0]             o_entry_initiator,
    output logic [15:0]             o_entry_responder,
    output logic signed [31:0]      o_entry_range
);
    import tfoc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tfoc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tfoc_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_op                (i_op),
        .i_slot_id           (i_slot_id),
        .i_initiator_id      (i_initiator_id),
        .i_responder_id      (i_responder_id),
        .i_range_difference  (i_range_difference),
        .i_value_invalid     (i_value_invalid),
        .i_read_index        (i_read_index),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_obs_count         (o_obs_count),
        .o_solvable          (o_solvable),
        .o_frame_complete    (o_frame_complete),
        .o_entry_slot_id     (o_entry_slot_id),
        .o_entry_initiator   (o_entry_initiator),
        .o_entry_responder   (o_entry_responder),
        .o_entry_range       (o_entry_range)
    );
endmodule
`default_nettype wire

@@ rtl/tfoc_ram.sv @@
`default_nettype none
module tfoc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/tfoc_div.sv @@
`default_nettype none
module tfoc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [7:0]  i_divisor,
    output logic             o_done,
    output logic      [31:0] o_quotient
);
    // restoring divide, one quotient bit per cycle
    logic [31:0] r_q, n_q;
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_d;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [8:0]  w_trial;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_q[31]};
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_d}) begin
                n_rem = 8'(w_trial - {1'b0, r_d});
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = w_trial[7:0];
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_d <= i_divisor;
        end
    end

    assign o_done     = !r_busy && !i_start;
    assign o_quotient = r_q;
endmodule
`default_nettype wire

@@ rtl/tfoc_ctrl.sv @@
`default_nettype none
module tfoc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire tfoc_pkg::t_sts i_sts,
    output tfoc_pkg::t_cmd      o_cmd
);
    import tfoc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // decode the captured item
                case (i_sts.op)
                    OP_INGEST: begin
                        if (!i_sts.cfg_ok || i_sts.item_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status = ST_REJECTED;
                            n_state = S_OUT;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state = S_FRAME;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = ST_OK;
                        n_state = S_OUT;
                    end
                    OP_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state = S_READ_RD;
                    end
                    default: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = ST_REJECTED;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_FRAME: begin
                if (i_sts.div_done) begin
                    o_cmd.scan_init = 1'b1;
                    if (!i_sts.active) begin
                        o_cmd.open_frame = 1'b1;
                        n_state = S_SCAN_RD;
                    end else if (i_sts.frame_neg) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = ST_REJECTED;
                        n_state = S_OUT;
                    end else if (!i_sts.frame_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = ST_BOUNDARY;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_state = S_STORE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = ST_DUPLICATE;
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_STORE: begin
                o_cmd.set_status = 1'b1;
                if (i_sts.full) begin
                    o_cmd.status = ST_REJECTED;
                end else begin
                    o_cmd.store = 1'b1;
                    o_cmd.status = i_sts.complete_after ? ST_COMPLETE : ST_OK;
                end
                n_state = S_OUT;
            end
            S_READ_RD: begin
                // hold the read address so the entry is still there next cycle
                o_cmd.rd_issue = 1'b1;
                n_state = S_READ_OUT;
            end
            S_READ_OUT: begin
                o_cmd.set_status = 1'b1;
                o_cmd.status = i_sts.read_ok ? ST_OK : ST_REJECTED;
                o_cmd.capture_entry = i_sts.read_ok;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/tfoc_dp.sv @@
`default_nettype none
module tfoc_dp #(
    parameter int unsigned CAPACITY = tfoc_pkg::CAPACITY_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [7:0]      i_cfg_data,
    input  wire logic [1:0]      i_op,
    input  wire logic [31:0]     i_slot_id,
    input  wire logic [15:0]     i_initiator_id,
    input  wire logic [15:0]     i_responder_id,
    input  wire logic signed [31:0] i_range_difference,
    input  wire logic            i_value_invalid,
    input  wire logic [7:0]      i_read_index,
    input  wire tfoc_pkg::t_cmd  i_cmd,
    output tfoc_pkg::t_sts       o_sts,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [2:0]           o_status,
    output logic [7:0]           o_obs_count,
    output logic                 o_solvable,
    output logic                 o_frame_complete,
    output logic [31:0]          o_entry_slot_id,
    output logic [15:0]          o_entry_initiator,
    output logic [15:0]          o_entry_responder,
    output logic signed [31:0]   o_entry_range
);
    import tfoc_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned EW = 64;

    logic [7:0]  r_spf, r_rps, r_min;
    logic [1:0]  r_op;
    logic [31:0] r_slot, r_range;
    logic [15:0] r_ini, r_rsp;
    logic        r_bad;
    logic [7:0]  r_ridx;
    logic        r_active;
    logic [31:0] r_frame;
    logic [7:0]  r_count;
    logic [7:0]  r_scan;
    logic [2:0]  r_status;
    logic [EW-1:0] r_entry;
    logic [31:0] r_erange;
    logic        r_valid;
    logic [2:0]  r_out_status;
    logic [7:0]  r_out_count;
    logic        r_out_solvable;
    logic        r_out_complete;
    logic [EW-1:0] r_out_entry;
    logic [31:0] r_out_erange;

    logic [15:0] w_expected;
    logic        w_cfg_ok;
    logic        w_div_done;
    logic [31:0] w_quot, w_delta;
    logic [AW-1:0] w_raddr, w_waddr;
    logic [EW-1:0] w_rdata;
    logic [31:0] w_rrange;
    logic [7:0]  w_count_after;
    logic        w_solvable;
    logic        w_complete;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spf <= 8'd1;
            r_rps <= 8'd1;
            r_min <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SLOTS: r_spf <= i_cfg_data;
                REG_RESP:  r_rps <= i_cfg_data;
                REG_MIN:   r_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_expected = r_spf * r_rps;
    assign w_cfg_ok = (r_spf != 8'd0) && (r_rps != 8'd0) &&
                      (w_expected <= 16'(CAPACITY)) && (r_min != 8'd0) &&
                      ({8'd0, r_min} <= w_expected);

    tfoc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_slot),
        .i_divisor  (r_spf),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_delta = w_quot - r_frame;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_slot  <= i_slot_id;
            r_ini   <= i_initiator_id;
            r_rsp   <= i_responder_id;
            r_range <= i_range_difference;
            r_bad   <= i_value_invalid;
            r_ridx  <= i_read_index;
        end
        if (i_cmd.scan_init) begin
            r_scan <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan <= r_scan + 8'd1;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.capture_entry) begin
            r_entry  <= w_rdata;
            r_erange <= w_rrange;
        end else if (i_cmd.set_status) begin
            r_entry  <= '0;
            r_erange <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_frame  <= '0;
            r_count  <= '0;
        end else if (i_cmd.clear) begin
            r_active <= 1'b0;
            r_frame  <= '0;
            r_count  <= '0;
        end else begin
            if (i_cmd.open_frame) begin
                r_active <= 1'b1;
                r_frame  <= w_quot;
            end
            if (i_cmd.store) begin
                r_count <= w_count_after;
            end
        end
    end

    assign w_count_after = r_count + 8'd1;
    assign w_raddr = i_cmd.rd_issue ? r_ridx[AW-1:0] : r_scan[AW-1:0];
    assign w_waddr = r_count[AW-1:0];

    tfoc_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (w_waddr),
        .i_wdata ({r_slot, r_ini, r_rsp}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tfoc_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_range_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (w_waddr),
        .i_wdata (r_range),
        .i_raddr (w_raddr),
        .o_rdata (w_rrange)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign w_solvable = r_active && (r_min != 8'd0) && (r_count >= r_min);
    assign w_complete = r_active && (w_expected != 16'd0) &&
                        ({8'd0, r_count} == w_expected);

    // result fields are frozen here so the next item can run while this one waits
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status   <= r_status;
            r_out_count    <= r_count;
            r_out_solvable <= w_solvable;
            r_out_complete <= w_complete;
            r_out_entry    <= r_entry;
            r_out_erange   <= r_erange;
        end
    end

    always_comb begin
        o_sts = '0;
        o_sts.op         = r_op;
        o_sts.cfg_ok     = w_cfg_ok;
        o_sts.item_bad   = (r_ini == r_rsp) || r_bad;
        o_sts.div_done   = w_div_done;
        o_sts.active     = r_active;
        o_sts.frame_neg  = w_delta[31];
        o_sts.frame_zero = (w_delta == 32'd0);
        o_sts.scan_end   = (r_scan >= r_count) || ({8'd0, r_scan} >= 16'(CAPACITY));
        o_sts.match      = (w_rdata == {r_slot, r_ini, r_rsp});
        o_sts.full       = ({8'd0, r_count} >= 16'(CAPACITY)) ||
                           ({8'd0, r_count} >= w_expected);
        o_sts.complete_after = ({8'd0, w_count_after} == w_expected);
        o_sts.read_ok    = (r_ridx < r_count) && ({8'd0, r_ridx} < 16'(CAPACITY));
        o_sts.out_busy   = r_valid && i_stall;
    end

    assign o_valid             = r_valid;
    assign o_status            = r_out_status;
    assign o_obs_count         = r_out_count;
    assign o_solvable          = r_out_solvable;
    assign o_frame_complete    = r_out_complete;
    assign o_entry_slot_id     = r_out_entry[63:32];
    assign o_entry_initiator   = r_out_entry[31:16];
    assign o_entry_responder   = r_out_entry[15:0];
    assign o_entry_range       = r_out_erange;
endmodule
`default_nettype wire

@@ rtl/tfoc_checker.sv @@
`default_nettype none
module tfoc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_status,
    input wire logic       o_frame_complete,
    input wire logic [31:0] o_entry_slot_id
);
    import tfoc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result dropped under stall");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second transaction taken while busy");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_REJECTED))
        else $error("bad status code");

    a_complete_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_COMPLETE |-> o_frame_complete)
        else $error("complete without full frame");

    a_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_entry_slot_id == 32'd0)
        else $error("entry data on non-read result");
endmodule

bind tdoa_frame_observation_collector tfoc_checker u_tfoc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_status            (o_status),
    .o_frame_complete    (o_frame_complete),
    .o_entry_slot_id     (o_entry_slot_id)
);
`default_nettype wire
